@@ rtl/core/alc_pkg.sv @@
// ----------------------------------------------------------------------------
// alc_pkg
// Shared widths, segment tables and pipeline payload types for the lux core.
// ----------------------------------------------------------------------------
package alc_pkg;

	// Input and datapath widths
	localparam int IN_W       = 16;
	localparam int COUNT_BITS = 16;
	localparam int SCALE_FRAC = 10;
	localparam int RATIO_FRAC = 9;
	localparam int LUX_FRAC   = 14;
	localparam int GAIN_SHIFT = 4;
	localparam int SCALE_W    = 19;
	localparam int CH_W       = COUNT_BITS + SCALE_W - SCALE_FRAC;
	localparam int QUO_W      = 12;
	localparam int NUM_W      = CH_W + RATIO_FRAC + 1;
	localparam int DEN_W      = CH_W + QUO_W - 1;
	localparam int SAT_SHIFT  = QUO_W - RATIO_FRAC - 1;
	localparam int SLOPE_W    = 10;
	localparam int KNEE_W     = 10;
	localparam int PROD_W     = CH_W + SLOPE_W;
	localparam int BAND_W     = 3;
	localparam int LUX_W      = 21;
	localparam int NUM_KNEES  = 7;
	localparam int NUM_BANDS  = 8;
	localparam int CFG_W      = 2;
	localparam int CFG_IDX_W  = 1;

	localparam logic [LUX_W-1:0]  LUX_MAX   = {LUX_W{1'b1}};
	localparam logic [BAND_W-1:0] BAND_LAST = BAND_W'(NUM_BANDS - 1);

	// Integration time codes
	localparam logic [1:0] INTEG_13MS  = 2'd0;
	localparam logic [1:0] INTEG_101MS = 2'd1;
	localparam logic [1:0] INTEG_402MS = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INTEG = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 1'b1;

	localparam logic [SCALE_W-1:0] SCALE_T13  = SCALE_W'(16'h7517);
	localparam logic [SCALE_W-1:0] SCALE_T101 = SCALE_W'(16'h0FE7);
	localparam logic [SCALE_W-1:0] SCALE_ONE  = SCALE_W'(1 << SCALE_FRAC);

	localparam logic [KNEE_W-1:0] SEG_KNEE [NUM_KNEES] = '{
		10'h040, 10'h080, 10'h0C0, 10'h100, 10'h138, 10'h19A, 10'h29A
	};
	localparam logic [SLOPE_W-1:0] SEG_B [NUM_BANDS] = '{
		10'h1F2, 10'h214, 10'h23F, 10'h270, 10'h16F, 10'h0D2, 10'h018, 10'h000
	};
	localparam logic [SLOPE_W-1:0] SEG_M [NUM_BANDS] = '{
		10'h1BE, 10'h2D1, 10'h37B, 10'h3FE, 10'h1FC, 10'h0FB, 10'h012, 10'h000
	};

	typedef struct packed {
		logic [CH_W-1:0] ch0;
		logic [CH_W-1:0] ch1;
	} chan_t;

	typedef struct packed {
		chan_t            ch;
		logic [NUM_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [QUO_W-1:0] quo;
		logic             sat;
		logic             zero;
	} div_t;

	typedef struct packed {
		chan_t             ch;
		logic [BAND_W-1:0] band;
	} band_t;

	typedef struct packed {
		logic [PROD_W-1:0] pos;
		logic [PROD_W-1:0] neg;
		logic [BAND_W-1:0] band;
	} mul_t;

	function automatic logic [SCALE_W-1:0] scale_sel(input logic [1:0] isel, input logic hg);
		logic [SCALE_W-1:0] s;
		case (isel)
			INTEG_13MS:  s = SCALE_T13;
			INTEG_101MS: s = SCALE_T101;
			default:     s = SCALE_ONE;
		endcase
		if (!hg) begin
			s = s << GAIN_SHIFT;
		end
		return s;
	endfunction

endpackage

@@ rtl/core/alc_scale.sv @@
// ----------------------------------------------------------------------------
// alc_scale
// First stage: masks both counts and scales them for integration time and gain.
// ----------------------------------------------------------------------------
module alc_scale (
	input  logic                   clk,
	input  logic                   en,
	input  logic [alc_pkg::IN_W-1:0] broadband_count,
	input  logic [alc_pkg::IN_W-1:0] infrared_count,
	input  logic [1:0]             integration_select,
	input  logic                   high_gain,
	output alc_pkg::chan_t         ch_s1
);
	import alc_pkg::*;

	logic [SCALE_W-1:0]            scale;
	logic [COUNT_BITS+SCALE_W-1:0] p0;
	logic [COUNT_BITS+SCALE_W-1:0] p1;

	always_comb begin
		scale = scale_sel(integration_select, high_gain);
		p0 = {{SCALE_W{1'b0}}, broadband_count[COUNT_BITS-1:0]} *
		     {{COUNT_BITS{1'b0}}, scale};
		p1 = {{SCALE_W{1'b0}}, infrared_count[COUNT_BITS-1:0]} *
		     {{COUNT_BITS{1'b0}}, scale};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ch_s1.ch0 <= p0[SCALE_FRAC +: CH_W];
			ch_s1.ch1 <= p1[SCALE_FRAC +: CH_W];
		end
	end

endmodule

@@ rtl/core/alc_div_step.sv @@
// ----------------------------------------------------------------------------
// alc_div_step
// One restoring division stage: develops one quotient bit of ch1/ch0.
// ----------------------------------------------------------------------------
module alc_div_step (
	input  logic          clk,
	input  logic          en,
	input  alc_pkg::div_t d,
	output alc_pkg::div_t div_s
);
	import alc_pkg::*;

	logic             ge;
	logic [NUM_W-1:0] rem_nxt;

	always_comb begin
		ge      = {{(DEN_W-NUM_W){1'b0}}, d.rem} >= d.den;
		rem_nxt = ge ? (d.rem - d.den[NUM_W-1:0]) : d.rem;
	end

	// The divisor walks down one bit per stage instead of the remainder shifting up.
	always_ff @(posedge clk) begin
		if (en) begin
			div_s.ch   <= d.ch;
			div_s.rem  <= rem_nxt;
			div_s.den  <= d.den >> 1;
			div_s.quo  <= {d.quo[QUO_W-2:0], ge};
			div_s.sat  <= d.sat;
			div_s.zero <= d.zero;
		end
	end

endmodule

@@ rtl/core/alc_band.sv @@
// ----------------------------------------------------------------------------
// alc_band
// Rounds the ratio and picks the slope/offset segment it falls in.
// ----------------------------------------------------------------------------
module alc_band (
	input  logic           clk,
	input  logic           en,
	input  alc_pkg::div_t  d,
	output alc_pkg::band_t band_s
);
	import alc_pkg::*;

	logic [QUO_W:0]    inc;
	logic [QUO_W-1:0]  rnd;
	logic [BAND_W-1:0] cnt;
	logic [BAND_W-1:0] band;

	// Knees ascend, so the band is the number of knees the ratio lies above.
	always_comb begin
		inc = {1'b0, d.quo} + (QUO_W+1)'(1);
		rnd = inc[QUO_W:1];
		cnt = '0;
		for (int i = 0; i < NUM_KNEES; i++) begin
			if (rnd > QUO_W'(SEG_KNEE[i])) begin
				cnt = cnt + BAND_W'(1);
			end
		end
		if (d.zero) begin
			band = '0;
		end else if (d.sat) begin
			band = BAND_LAST;
		end else begin
			band = cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			band_s.ch   <= d.ch;
			band_s.band <= band;
		end
	end

endmodule

@@ rtl/core/alc_mul.sv @@
// ----------------------------------------------------------------------------
// alc_mul
// Looks up the segment coefficients and forms both weighted channel products.
// ----------------------------------------------------------------------------
module alc_mul (
	input  logic           clk,
	input  logic           en,
	input  alc_pkg::band_t d,
	output alc_pkg::mul_t  mul_s
);
	import alc_pkg::*;

	logic [SLOPE_W-1:0] b;
	logic [SLOPE_W-1:0] m;
	logic [PROD_W-1:0]  pos;
	logic [PROD_W-1:0]  neg;

	always_comb begin
		b   = SEG_B[d.band];
		m   = SEG_M[d.band];
		pos = {{SLOPE_W{1'b0}}, d.ch.ch0} * {{CH_W{1'b0}}, b};
		neg = {{SLOPE_W{1'b0}}, d.ch.ch1} * {{CH_W{1'b0}}, m};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mul_s.pos  <= pos;
			mul_s.neg  <= neg;
			mul_s.band <= d.band;
		end
	end

endmodule

@@ rtl/core/ambient_light_lux_calc_core.sv @@
// ----------------------------------------------------------------------------
// ambient_light_lux_calc_core
// Two-channel lux approximation: scale, ratio divide, segment pick, products.
// ----------------------------------------------------------------------------
//   Channel   Handshake                Payload
//   input     in_valid / in_ready      broadband_count, infrared_count
//   output    out_valid / out_ready    lux, ratio_band
//   config    cfg_write                cfg_index, cfg_data
//
// Seventeen register stages; a new beat may enter every cycle unless every
// stage is full and out_ready is low. Twelve of them are restoring divider
// stages, one quotient bit each. Reset clears every stage valid bit and loads
// the registers with 402 ms and low gain. Each stage has its own ready, so a
// stalled output holds its beat while bubbles further up are still filled.
// ----------------------------------------------------------------------------
module ambient_light_lux_calc_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [alc_pkg::IN_W-1:0]          broadband_count,
	input  logic [alc_pkg::IN_W-1:0]          infrared_count,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [alc_pkg::LUX_W-1:0]         lux,
	output logic [alc_pkg::BAND_W-1:0]        ratio_band,
	input  logic                              cfg_write,
	input  logic [alc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [alc_pkg::CFG_W-1:0]         cfg_data
);
	import alc_pkg::*;

	localparam int ST_PREP    = 1;
	localparam int ST_DIV0    = 2;
	localparam int ST_BAND    = ST_DIV0 + QUO_W;
	localparam int ST_MUL     = ST_BAND + 1;
	localparam int ST_OUT     = ST_MUL + 1;
	localparam int NST        = ST_OUT + 1;
	localparam int LUX_FULL_W = PROD_W - LUX_FRAC + 1;

	logic [1:0]           integration_select_q;
	logic                 high_gain_q;
	logic [NST-1:0]       v_q;
	logic [NST-1:0]       rdy;
	logic [NST-1:0]       v_in;

	chan_t                ch_s1;
	div_t                 prep_s2;
	div_t                 div_pipe [QUO_W+1];
	band_t                band_s15;
	mul_t                 mul_s16;
	logic [LUX_W-1:0]     lux_s17;
	logic [BAND_W-1:0]    band_s17;

	logic [PROD_W-1:0]     diff;
	logic [PROD_W:0]       rsum;
	logic [LUX_FULL_W-1:0] lux_full;
	logic [LUX_W-1:0]      lux_sat;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integration_select_q <= INTEG_402MS;
			high_gain_q          <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_INTEG: integration_select_q <= cfg_data[1:0];
				REG_GAIN:  high_gain_q          <= cfg_data[0];
			endcase
		end
	end

	// A stage may load when it is empty or when everything below it can move.
	for (genvar i = 0; i < NST; i++) begin : g_rdy
		assign rdy[i] = out_ready || !(&v_q[NST-1:i]);
	end

	assign v_in = {v_q[NST-2:0], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int i = 0; i < NST; i++) begin
				if (rdy[i]) begin
					v_q[i] <= v_in[i];
				end
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = v_q[ST_OUT];

	alc_scale u_scale (
		.clk                (clk),
		.en                 (rdy[0]),
		.broadband_count    (broadband_count),
		.infrared_count     (infrared_count),
		.integration_select (integration_select_q),
		.high_gain          (high_gain_q),
		.ch_s1              (ch_s1)
	);

	// Divider setup: ch1 << 10 over ch0, with twelve quotient bits. A ratio
	// that would need more bits lands in the last band anyway.
	always_ff @(posedge clk) begin
		if (rdy[ST_PREP]) begin
			prep_s2.ch   <= ch_s1;
			prep_s2.rem  <= {ch_s1.ch1, {(RATIO_FRAC+1){1'b0}}};
			prep_s2.den  <= {ch_s1.ch0, {(QUO_W-1){1'b0}}};
			prep_s2.quo  <= '0;
			prep_s2.sat  <= {{SAT_SHIFT{1'b0}}, ch_s1.ch1} >=
			                {ch_s1.ch0, {SAT_SHIFT{1'b0}}};
			prep_s2.zero <= (ch_s1.ch0 == '0);
		end
	end

	assign div_pipe[0] = prep_s2;

	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		alc_div_step u_step (
			.clk   (clk),
			.en    (rdy[ST_DIV0+k]),
			.d     (div_pipe[k]),
			.div_s (div_pipe[k+1])
		);
	end

	alc_band u_band (
		.clk    (clk),
		.en     (rdy[ST_BAND]),
		.d      (div_pipe[QUO_W]),
		.band_s (band_s15)
	);

	alc_mul u_mul (
		.clk   (clk),
		.en    (rdy[ST_MUL]),
		.d     (band_s15),
		.mul_s (mul_s16)
	);

	// Clamp at zero, round, drop the fraction and saturate.
	always_comb begin
		diff     = (mul_s16.pos > mul_s16.neg) ? (mul_s16.pos - mul_s16.neg) : '0;
		rsum     = {1'b0, diff} + (PROD_W+1)'(1 << (LUX_FRAC - 1));
		lux_full = rsum[PROD_W:LUX_FRAC];
		lux_sat  = (lux_full > LUX_FULL_W'(LUX_MAX)) ? LUX_MAX : lux_full[LUX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (rdy[ST_OUT]) begin
			lux_s17  <= lux_sat;
			band_s17 <= mul_s16.band;
		end
	end

	assign lux        = lux_s17;
	assign ratio_band = band_s17;

	// The last segment has zero slope and offset, so it can only give zero lux.
	a_last_band_dark : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (ratio_band == BAND_LAST) |-> (lux == '0))
		else $error("last ratio band produced nonzero lux");

	// After the final divider stage the remainder is below the divisor.
	a_div_remainder : assert property (@(posedge clk) disable iff (!arst_n)
		v_q[ST_BAND-1] && !div_pipe[QUO_W].zero && !div_pipe[QUO_W].sat
		|-> (div_pipe[QUO_W].rem < NUM_W'(div_pipe[QUO_W].ch.ch0)))
		else $error("divider remainder not below divisor");

	// A zero broadband count always selects the first band.
	a_zero_band : assert property (@(posedge clk) disable iff (!arst_n)
		rdy[ST_BAND] && v_q[ST_BAND-1] && div_pipe[QUO_W].zero
		|=> (band_s15.band == '0))
		else $error("zero broadband count did not select band zero");

endmodule
